/* src/rfd_pkg.sv */
// Shared types and constants for the radar frame delimiter.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

    // Parser state: waiting for a head, or inside a frame of a given kind.
    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_SHORT    = 2'd1,
        MODE_STANDARD = 2'd2,
        MODE_COMMAND  = 2'd3
    } mode_t;

    // Frame kind codes as seen on the output.
    localparam logic [1:0] KIND_SHORT    = 2'd0;
    localparam logic [1:0] KIND_STANDARD = 2'd1;
    localparam logic [1:0] KIND_COMMAND  = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_SHORT_HEAD    = 3'd0;
    localparam logic [2:0] REG_SHORT_TAIL    = 3'd1;
    localparam logic [2:0] REG_STANDARD_HEAD = 3'd2;
    localparam logic [2:0] REG_STANDARD_TAIL = 3'd3;
    localparam logic [2:0] REG_COMMAND_HEAD  = 3'd4;
    localparam logic [2:0] REG_COMMAND_TAIL  = 3'd5;
    localparam logic [2:0] REG_SHORT_LIMIT   = 3'd6;
    localparam logic [2:0] REG_LONG_LIMIT    = 3'd7;

    // Reset values of the registers.
    localparam logic [7:0]  RST_SHORT_HEAD    = 8'h00;
    localparam logic [7:0]  RST_SHORT_TAIL    = 8'h00;
    localparam logic [31:0] RST_STANDARD_HEAD = 32'hF4F3F2F1;
    localparam logic [31:0] RST_STANDARD_TAIL = 32'hF8F7F6F5;
    localparam logic [31:0] RST_COMMAND_HEAD  = 32'hFDFCFBFA;
    localparam logic [31:0] RST_COMMAND_TAIL  = 32'h04030201;
    localparam logic [7:0]  RST_SHORT_LIMIT   = 8'd5;
    localparam logic [7:0]  RST_LONG_LIMIT    = 8'd250;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // Current configuration, handed from the register file to the parser.
    typedef struct packed {
        logic [7:0]  short_head_byte;
        logic [7:0]  short_tail_byte;
        logic [31:0] standard_head_word;
        logic [31:0] standard_tail_word;
        logic [31:0] command_head_word;
        logic [31:0] command_tail_word;
        logic [7:0]  short_length_limit;
        logic [7:0]  long_length_limit;
    } cfg_t;

    // Results produced by one received byte: up to four bytes, first byte in
    // the top lane. Last and limit flags belong to the final byte.
    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  count;
        logic [1:0]  kind;
        logic        last;
        logic        by_limit;
    } bundle_t;

endpackage

`default_nettype wire

/* src/radar_frame_delimiter.sv */
// Top level of the radar frame delimiter: input register, parser, result
// buffer and configuration port. Depends on rfd_pkg, rfd_regfile, rfd_parser.
`timescale 1ns / 1ps
`default_nettype none

// The delimiter takes one received byte per input transaction and finds
// frames in the stream. A short frame opens on a single head byte; standard
// and command frames open when the last four bytes equal their head word, and
// then all four head bytes are sent, first byte first. Every later byte goes
// out tagged with its frame kind, and the closing byte (tail or length limit)
// carries frame_last, with ended_by_limit set when the limit and not the
// tail closed the frame. An accepted byte sits in an input register, is
// parsed combinationally and its results move into a result buffer that
// feeds the output. The block takes a byte on every cycle while the output
// keeps up and bytes give one result or none; a byte that opens a long
// frame gives four results and holds the next byte until the last has
// left. The input register lets one byte be accepted while a result still
// waits for the output side. Configuration registers sit at byte addresses
// 4*i and are meant to be written while the block is idle.

module radar_frame_delimiter
    import rfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Received bytes.
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    // Frame bytes.
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [7:0]  frame_byte,
    output logic      [1:0]  frame_kind,
    output logic             frame_last,
    output logic             ended_by_limit
);

    cfg_t        cfg;
    bundle_t     parse_result;

    // Input register.
    logic        in_full_reg, in_full_next;
    logic [7:0]  in_byte_reg;

    // Result buffer: remaining result count and the bytes still to send.
    logic [2:0]  buf_count_reg, buf_count_next;
    logic [31:0] buf_bytes_reg, buf_bytes_next;
    logic [1:0]  buf_kind_reg;
    logic        buf_last_reg;
    logic        buf_limit_reg;

    logic        out_take;
    logic        buf_free;
    logic        move;

    rfd_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The buffer can take the next byte's results once it is empty or its
    // final result leaves in this cycle.
    assign out_take = out_valid && out_ready;
    assign buf_free = (buf_count_reg == 3'd0) || ((buf_count_reg == 3'd1) && out_ready);
    assign move     = in_full_reg && buf_free;
    assign in_ready = !in_full_reg || move;

    rfd_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (move),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (parse_result)
    );

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_valid && in_ready)
        begin
            in_full_next = 1'b1;
        end
        else if (move)
        begin
            in_full_next = 1'b0;
        end
    end

    always_comb
    begin
        buf_count_next = buf_count_reg;
        buf_bytes_next = buf_bytes_reg;
        if (move)
        begin
            buf_count_next = parse_result.count;
            buf_bytes_next = parse_result.bytes;
        end
        else if (out_take)
        begin
            buf_count_next = buf_count_reg - 3'd1;
            buf_bytes_next = {buf_bytes_reg[23:0], 8'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            buf_count_reg <= 3'd0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            buf_count_reg <= buf_count_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
        buf_bytes_reg <= buf_bytes_next;
        if (move)
        begin
            buf_kind_reg  <= parse_result.kind;
            buf_last_reg  <= parse_result.last;
            buf_limit_reg <= parse_result.by_limit;
        end
    end

    // The end-of-frame flags belong to the final result of a byte only.
    assign out_valid      = (buf_count_reg != 3'd0);
    assign frame_byte     = buf_bytes_reg[31:24];
    assign frame_kind     = buf_kind_reg;
    assign frame_last     = buf_last_reg && (buf_count_reg == 3'd1);
    assign ended_by_limit = buf_limit_reg && (buf_count_reg == 3'd1);

endmodule

`default_nettype wire

/* src/rfd_regfile.sv */
// Configuration register file of the radar frame delimiter, APB-style access.
// Depends on rfd_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module rfd_regfile
    import rfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_head_byte    <= RST_SHORT_HEAD;
            cfg_reg.short_tail_byte    <= RST_SHORT_TAIL;
            cfg_reg.standard_head_word <= RST_STANDARD_HEAD;
            cfg_reg.standard_tail_word <= RST_STANDARD_TAIL;
            cfg_reg.command_head_word  <= RST_COMMAND_HEAD;
            cfg_reg.command_tail_word  <= RST_COMMAND_TAIL;
            cfg_reg.short_length_limit <= RST_SHORT_LIMIT;
            cfg_reg.long_length_limit  <= RST_LONG_LIMIT;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SHORT_HEAD:    cfg_reg.short_head_byte    <= pwdata[7:0];
                REG_SHORT_TAIL:    cfg_reg.short_tail_byte    <= pwdata[7:0];
                REG_STANDARD_HEAD: cfg_reg.standard_head_word <= pwdata;
                REG_STANDARD_TAIL: cfg_reg.standard_tail_word <= pwdata;
                REG_COMMAND_HEAD:  cfg_reg.command_head_word  <= pwdata;
                REG_COMMAND_TAIL:  cfg_reg.command_tail_word  <= pwdata;
                REG_SHORT_LIMIT:   cfg_reg.short_length_limit <= pwdata[7:0];
                REG_LONG_LIMIT:    cfg_reg.long_length_limit  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SHORT_HEAD:    prdata = {24'd0, cfg_reg.short_head_byte};
            REG_SHORT_TAIL:    prdata = {24'd0, cfg_reg.short_tail_byte};
            REG_STANDARD_HEAD: prdata = cfg_reg.standard_head_word;
            REG_STANDARD_TAIL: prdata = cfg_reg.standard_tail_word;
            REG_COMMAND_HEAD:  prdata = cfg_reg.command_head_word;
            REG_COMMAND_TAIL:  prdata = cfg_reg.command_tail_word;
            REG_SHORT_LIMIT:   prdata = {24'd0, cfg_reg.short_length_limit};
            REG_LONG_LIMIT:    prdata = {24'd0, cfg_reg.long_length_limit};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

/* src/rfd_parser.sv */
// Frame parser: byte window, parse mode and frame count, plus the head and
// tail decisions for one byte. Depends on rfd_pkg for mode_t, cfg_t, bundle_t.
`timescale 1ns / 1ps
`default_nettype none

module rfd_parser
    import rfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] rx_byte,
    input  wire cfg_t       cfg,
    output bundle_t         result
);

    mode_t       mode_reg,   mode_next;
    logic [31:0] window_reg, window_next;
    logic [7:0]  count_reg,  count_next;
    logic [7:0]  count_inc;
    logic        tail_hit;
    logic        limit_hit;
    logic [1:0]  cur_kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            window_reg <= 32'd0;
            count_reg  <= 8'd0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            window_reg <= window_next;
            count_reg  <= count_next;
        end
    end

    assign window_next = {window_reg[23:0], rx_byte};
    assign count_inc   = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 8'd1;

    // Tail and limit tests for a byte inside a frame.
    always_comb
    begin
        case (mode_reg)
            MODE_SHORT:
            begin
                cur_kind  = KIND_SHORT;
                tail_hit  = (rx_byte == cfg.short_tail_byte);
                limit_hit = (count_inc >= cfg.short_length_limit);
            end
            MODE_STANDARD:
            begin
                cur_kind  = KIND_STANDARD;
                tail_hit  = (window_next == cfg.standard_tail_word);
                limit_hit = (count_inc >= cfg.long_length_limit);
            end
            default:
            begin
                cur_kind  = KIND_COMMAND;
                tail_hit  = (window_next == cfg.command_tail_word);
                limit_hit = (count_inc >= cfg.long_length_limit);
            end
        endcase
    end

    always_comb
    begin
        mode_next       = mode_reg;
        count_next      = count_reg;
        result.bytes    = {rx_byte, 24'd0};
        result.count    = 3'd0;
        result.kind     = cur_kind;
        result.last     = 1'b0;
        result.by_limit = 1'b0;
        if (mode_reg == MODE_IDLE)
        begin
            if (rx_byte == cfg.short_head_byte)
            begin
                mode_next    = MODE_SHORT;
                count_next   = 8'd1;
                result.count = 3'd1;
                result.kind  = KIND_SHORT;
            end
            else if (window_next == cfg.standard_head_word)
            begin
                mode_next    = MODE_STANDARD;
                count_next   = 8'd4;
                result.bytes = window_next;
                result.count = 3'd4;
                result.kind  = KIND_STANDARD;
            end
            else if (window_next == cfg.command_head_word)
            begin
                mode_next    = MODE_COMMAND;
                count_next   = 8'd4;
                result.bytes = window_next;
                result.count = 3'd4;
                result.kind  = KIND_COMMAND;
            end
        end
        else
        begin
            count_next   = count_inc;
            result.count = 3'd1;
            if (tail_hit || limit_hit)
            begin
                mode_next       = MODE_IDLE;
                result.last     = 1'b1;
                result.by_limit = limit_hit && !tail_hit;
            end
        end
    end

endmodule

`default_nettype wire
